// ===== hw/rtl/pcc_pkg.sv =====
// Shared widths, register indexes, reset values and types for the clamped PID controller.
package pcc_pkg;

  localparam int unsigned InW     = 12;  // setpoint and measured
  localparam int unsigned ErrW    = 13;  // setpoint - measured
  localparam int unsigned DiffW   = 14;  // err - last_error
  localparam int unsigned AccW    = 18;  // integral accumulator
  localparam int unsigned RegW    = 16;  // configuration registers
  localparam int unsigned IdxW    = 3;
  localparam int unsigned PropW   = RegW + 1 + ErrW;   // 30
  localparam int unsigned IntegW  = RegW + 1 + AccW;   // 35
  localparam int unsigned DerivW  = RegW + 1 + DiffW;  // 31
  localparam int unsigned DriveW  = 36;
  localparam int unsigned DutyW   = 16;
  localparam int unsigned SInDataW  = 24;
  localparam int unsigned MOutDataW = 16;

  localparam logic signed [RegW-1:0] CeilingReset = 16'sd100;
  localparam logic signed [RegW-1:0] FloorReset   = 16'sd0;
  localparam logic [RegW-1:0]        LimitReset   = 16'd20;

  typedef enum logic [IdxW-1:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_INTEG_GAIN = 3'd1,
    CFG_DERIV_GAIN = 3'd2,
    CFG_BIAS       = 3'd3,
    CFG_CEILING    = 3'd4,
    CFG_FLOOR      = 3'd5,
    CFG_INT_LIMIT  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [RegW-1:0]        prop_gain;
    logic [RegW-1:0]        integ_gain;
    logic [RegW-1:0]        deriv_gain;
    logic [RegW-1:0]        output_bias;
    logic signed [RegW-1:0] duty_ceiling;
    logic signed [RegW-1:0] duty_floor;
    logic [RegW-1:0]        integral_limit;
  } cfg_t;

  // Beat leaving the error stage
  typedef struct packed {
    logic                    valid;
    logic signed [ErrW-1:0]  err;
    logic signed [AccW-1:0]  acc;
    logic signed [DiffW-1:0] diff;
  } err_beat_t;

  // Beat leaving the sum stage
  typedef struct packed {
    logic                     valid;
    logic signed [DriveW-1:0] drive;
  } drive_beat_t;

endpackage

// ===== hw/rtl/pid_controller_clamped.sv =====
// Top level of the clamped-integral PID controller.
//
//  channel   dir  fields (low bit up)                         beat taken when
//  s_axis    in   tdata: setpoint[11:0] measured[23:12]         tvalid && tready
//  m_axis    out  tdata: duty[15:0]                             tvalid && tready
//  cfg       in   cfg_idx_i, cfg_data_i                         cfg_we_i high
//
// Four-stage pipeline: error/accumulator, gain products, drive sum, saturation.
// A beat passes the stages in that order; its duty then waits in the output register
// until taken. One beat per cycle sustained unless the output stalls.
// The accumulator and previous error update in the cycle a beat is taken.
// The whole pipeline holds while the output register is full and m_axis_tready is low.
// Reset clears the state, the pipeline valids and loads the register reset values.
module pid_controller_clamped (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pcc_pkg::SInDataW-1:0]     s_axis_tdata,   // setpoint, measured
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pcc_pkg::MOutDataW-1:0]    m_axis_tdata,   // duty
  input  logic                             cfg_we_i,
  input  logic [pcc_pkg::IdxW-1:0]         cfg_idx_i,
  input  logic [pcc_pkg::RegW-1:0]         cfg_data_i
);
  import pcc_pkg::*;

  cfg_t                    cfg;
  err_beat_t               err_beat;
  drive_beat_t             drive_beat;
  logic                    en;
  logic                    accept;
  logic                    out_valid;
  logic signed [DutyW-1:0] duty;

  // advance unless a finished beat is stuck at the output
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  pcc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pcc_err_stage u_err (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .accept_i         (accept),
    .setpoint_i       (s_axis_tdata[InW-1:0]),
    .measured_i       (s_axis_tdata[2*InW-1:InW]),
    .integral_limit_i (cfg.integral_limit),
    .beat_o           (err_beat)
  );

  pcc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .beat_i (err_beat),
    .cfg_i  (cfg),
    .beat_o (drive_beat)
  );

  pcc_sat u_sat (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .beat_i    (drive_beat),
    .floor_i   (cfg.duty_floor),
    .ceiling_i (cfg.duty_ceiling),
    .valid_o   (out_valid),
    .duty_o    (duty)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = duty;

endmodule

// ===== hw/rtl/pcc_cfg_regs.sv =====
// Configuration register file of the clamped PID controller.
module pcc_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pcc_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [pcc_pkg::RegW-1:0]  cfg_data_i,
  output pcc_pkg::cfg_t             cfg_o
);
  import pcc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain      <= '0;
      cfg_q.integ_gain     <= '0;
      cfg_q.deriv_gain     <= '0;
      cfg_q.output_bias    <= '0;
      cfg_q.duty_ceiling   <= CeilingReset;
      cfg_q.duty_floor     <= FloorReset;
      cfg_q.integral_limit <= LimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROP_GAIN:  cfg_q.prop_gain      <= cfg_data_i;
        CFG_INTEG_GAIN: cfg_q.integ_gain     <= cfg_data_i;
        CFG_DERIV_GAIN: cfg_q.deriv_gain     <= cfg_data_i;
        CFG_BIAS:       cfg_q.output_bias    <= cfg_data_i;
        CFG_CEILING:    cfg_q.duty_ceiling   <= $signed(cfg_data_i);
        CFG_FLOOR:      cfg_q.duty_floor     <= $signed(cfg_data_i);
        CFG_INT_LIMIT:  cfg_q.integral_limit <= cfg_data_i;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/pcc_err_stage.sv =====
// Error, clamped integral accumulator and error change for each accepted beat.
module pcc_err_stage (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     accept_i,
  input  logic [pcc_pkg::InW-1:0]  setpoint_i,
  input  logic [pcc_pkg::InW-1:0]  measured_i,
  input  logic [pcc_pkg::RegW-1:0] integral_limit_i,
  output pcc_pkg::err_beat_t       beat_o
);
  import pcc_pkg::*;

  logic signed [AccW-1:0]  error_sum_q, error_sum_d;
  logic signed [ErrW-1:0]  last_error_q;
  logic signed [ErrW-1:0]  err;
  logic signed [AccW-1:0]  acc_raw;
  logic signed [AccW-1:0]  lim_pos;
  logic signed [AccW-1:0]  lim_neg;
  logic signed [DiffW-1:0] diff;
  logic                    valid_q;
  logic signed [ErrW-1:0]  err_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [DiffW-1:0] diff_q;

  always_comb begin
    err     = $signed({1'b0, setpoint_i}) - $signed({1'b0, measured_i});
    acc_raw = error_sum_q + AccW'(err);
    lim_pos = $signed({{(AccW-RegW){1'b0}}, integral_limit_i});
    lim_neg = -lim_pos;
    // upper bound wins, so a zero limit always yields zero
    if (acc_raw >= lim_pos) begin
      error_sum_d = lim_pos;
    end else if (acc_raw <= lim_neg) begin
      error_sum_d = lim_neg;
    end else begin
      error_sum_d = acc_raw;
    end
    diff = DiffW'(err) - DiffW'(last_error_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q  <= '0;
      last_error_q <= '0;
      valid_q      <= 1'b0;
    end else begin
      if (accept_i) begin
        error_sum_q  <= error_sum_d;
        last_error_q <= err;
      end
      if (en_i) begin
        valid_q <= accept_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      err_q  <= err;
      acc_q  <= error_sum_d;
      diff_q <= diff;
    end
  end

  assign beat_o.valid = valid_q;
  assign beat_o.err   = err_q;
  assign beat_o.acc   = acc_q;
  assign beat_o.diff  = diff_q;

endmodule

// ===== hw/rtl/pcc_mac.sv =====
// Gain products and full-width drive sum, one register stage each.
module pcc_mac (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  pcc_pkg::err_beat_t beat_i,
  input  pcc_pkg::cfg_t      cfg_i,
  output pcc_pkg::drive_beat_t beat_o
);
  import pcc_pkg::*;

  logic signed [PropW-1:0]  prop_prod;
  logic signed [IntegW-1:0] integ_prod;
  logic signed [DerivW-1:0] deriv_prod;
  logic signed [PropW-1:0]  prop_q;
  logic signed [IntegW-1:0] integ_q;
  logic signed [DerivW-1:0] deriv_q;
  logic                     prod_valid_q;
  logic signed [DriveW-1:0] drive_d;
  logic signed [DriveW-1:0] drive_q;
  logic                     drive_valid_q;

  always_comb begin
    prop_prod  = PropW'($signed({1'b0, cfg_i.prop_gain}))   * PropW'(beat_i.err);
    integ_prod = IntegW'($signed({1'b0, cfg_i.integ_gain})) * IntegW'(beat_i.acc);
    deriv_prod = DerivW'($signed({1'b0, cfg_i.deriv_gain})) * DerivW'(beat_i.diff);
    drive_d = DriveW'(prop_q) + DriveW'(integ_q) + DriveW'(deriv_q)
            + $signed({{(DriveW-RegW){1'b0}}, cfg_i.output_bias});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q  <= 1'b0;
      drive_valid_q <= 1'b0;
    end else if (en_i) begin
      prod_valid_q  <= beat_i.valid;
      drive_valid_q <= prod_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prop_q  <= prop_prod;
      integ_q <= integ_prod;
      deriv_q <= deriv_prod;
      drive_q <= drive_d;
    end
  end

  assign beat_o.valid = drive_valid_q;
  assign beat_o.drive = drive_q;

endmodule

// ===== hw/rtl/pcc_sat.sv =====
// Floor and ceiling saturation into the output register.
module pcc_sat (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  pcc_pkg::drive_beat_t        beat_i,
  input  logic signed [pcc_pkg::RegW-1:0] floor_i,
  input  logic signed [pcc_pkg::RegW-1:0] ceiling_i,
  output logic                        valid_o,
  output logic signed [pcc_pkg::DutyW-1:0] duty_o
);
  import pcc_pkg::*;

  logic signed [DriveW-1:0] floor_ext;
  logic signed [DriveW-1:0] ceil_ext;
  logic signed [DriveW-1:0] sat;
  logic                     valid_q;
  logic signed [DutyW-1:0]  duty_q;

  always_comb begin
    floor_ext = DriveW'(floor_i);
    ceil_ext  = DriveW'(ceiling_i);
    sat = beat_i.drive;
    // floor first, ceiling last: an inverted pair yields the ceiling
    if (sat < floor_ext) sat = floor_ext;
    if (sat > ceil_ext)  sat = ceil_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= beat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      duty_q <= sat[DutyW-1:0];
    end
  end

  assign valid_o = valid_q;
  assign duty_o  = duty_q;

endmodule

// ===== verif/tb_pid_controller_clamped.sv =====
// Self-checking testbench for pid_controller_clamped: predicts each duty beat and compares.
module tb_pid_controller_clamped;
  import pcc_pkg::*;

  localparam logic [IdxW-1:0] CfgSpare = 3'd7;  // unmapped index, must be ignored
  localparam int DrainCycles = 8;
  localparam int RandPhases = 12;
  localparam int RandPerPhase = 140;

  typedef struct packed {
    logic [InW-1:0] measured;
    logic [InW-1:0] setpoint;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 s_axis_tready;
  logic [SInDataW-1:0]  in_data = '0;
  logic                 m_axis_tvalid;
  logic                 out_ready = 1'b0;
  logic [MOutDataW-1:0] m_axis_tdata;
  logic                 cfg_we = 1'b0;
  logic [IdxW-1:0]      cfg_idx = '0;
  logic [RegW-1:0]      cfg_data = '0;

  pid_controller_clamped dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (in_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Controller image: register copies and loop state
  longint gain_p = 0;
  longint gain_i = 0;
  longint gain_d = 0;
  longint bias = 0;
  longint ceil_v = longint'(CeilingReset);
  longint floor_v = longint'(FloorReset);
  longint clamp_lim = longint'(LimitReset);
  longint err_acc = 0;
  longint prev_err = 0;

  sample_t         sample_q[$];
  logic [DutyW-1:0] duty_q[$];
  int queued_cnt = 0;
  int taken_cnt = 0;
  int checked_cnt = 0;
  int fail_cnt = 0;
  int settings_cnt = 0;

  function automatic logic [DutyW-1:0] next_duty(sample_t smp);
    longint err;
    longint acc;
    longint drive;
    err = longint'(smp.setpoint) - longint'(smp.measured);
    acc = err_acc + err;
    if (acc >= clamp_lim) acc = clamp_lim;
    else if (acc <= -clamp_lim) acc = -clamp_lim;
    err_acc = acc;
    drive = gain_p * err + gain_i * acc + gain_d * (err - prev_err) + bias;
    // floor first, ceiling wins when the two cross
    if (drive < floor_v) drive = floor_v;
    if (drive > ceil_v) drive = ceil_v;
    prev_err = err;
    return drive[DutyW-1:0];
  endfunction

  // Driver: bursts of beats from the sample queue with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && s_axis_tready) begin
        duty_q.push_back(next_duty(sample_t'(in_data)));
        taken_cnt++;
      end
      if (!in_valid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= sample_q.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check duty beats and stall the output on a changing pattern
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk_i) begin
    logic [DutyW-1:0] want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid && out_ready) begin
        if (duty_q.size() == 0) begin
          $display("%0t duty beat with nothing expected: expected none, actual %0d",
                   $time, $signed(m_axis_tdata));
          fail_cnt++;
        end else begin
          want = duty_q.pop_front();
          if (m_axis_tdata !== want) begin
            $display("%0t duty mismatch: expected %0d, actual %0d",
                     $time, $signed(want), $signed(m_axis_tdata));
            fail_cnt++;
          end
        end
        checked_cnt++;
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (stall_left % 4 == 0);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic set_reg(logic [IdxW-1:0] idx, logic [RegW-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CFG_PROP_GAIN:  gain_p = longint'(val);
      CFG_INTEG_GAIN: gain_i = longint'(val);
      CFG_DERIV_GAIN: gain_d = longint'(val);
      CFG_BIAS:       bias = longint'(val);
      CFG_CEILING:    ceil_v = longint'($signed(val));
      CFG_FLOOR:      floor_v = longint'($signed(val));
      CFG_INT_LIMIT:  clamp_lim = longint'(val);
      default: ;
    endcase
  endtask

  task automatic load_config(int p, int i, int d, int b, int c, int f, int lim);
    set_reg(CFG_PROP_GAIN, 16'(p));
    set_reg(CFG_INTEG_GAIN, 16'(i));
    set_reg(CFG_DERIV_GAIN, 16'(d));
    set_reg(CFG_BIAS, 16'(b));
    set_reg(CFG_CEILING, 16'(c));
    set_reg(CFG_FLOOR, 16'(f));
    set_reg(CFG_INT_LIMIT, 16'(lim));
    if ($urandom_range(0, 2) == 0) set_reg(CfgSpare, 16'($urandom));
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings_cnt++;
  endtask

  task automatic add_sample(int sp, int mv);
    sample_t smp;
    smp.setpoint = InW'(sp);
    smp.measured = InW'(mv);
    sample_q.push_back(smp);
    queued_cnt++;
  endtask

  // Every sample yields one duty, so idle means all queued samples came back
  task automatic wait_idle();
    while (checked_cnt < queued_cnt) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic int pick_gain();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65535;
      2, 3, 4, 5: return $urandom_range(0, 64);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      2, 3: return $urandom_range(1, 300);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int clip_in(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  task automatic add_random_sample(bit push_up);
    int s;
    int m;
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) begin
      // hover near the setpoint
      s = $urandom_range(0, 4095);
      m = clip_in(s + $urandom_range(0, 128) - 64);
    end else if (k < 7) begin
      s = $urandom_range(0, 4095);
      m = $urandom_range(0, 4095);
    end else if (k == 7) begin
      s = $urandom_range(0, 1) ? 4095 : 0;
      m = $urandom_range(0, 1) ? 4095 : 0;
    end else begin
      // steady push in one direction to wind the accumulator up
      s = 4095 - $urandom_range(0, 200);
      m = $urandom_range(0, 200);
      if (!push_up) begin
        k = s;
        s = m;
        m = k;
      end
    end
    add_sample(s, m);
  endtask

  initial begin
    int c;
    int f;
    int a;
    int b;
    bit up;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset values: zero gains, output held at the floor
    add_sample(4095, 0);
    add_sample(0, 4095);
    add_sample(2048, 2048);
    wait_idle();

    // unit gains, full range, default limit: walk the accumulator into both bounds
    set_reg(CfgSpare, 16'hFFFF);
    load_config(1, 1, 1, 0, 32767, -32768, 20);
    repeat (3) add_sample(100, 0);
    repeat (3) add_sample(0, 100);
    add_sample(4095, 0);
    add_sample(0, 4095);
    add_sample(5, 5);
    wait_idle();

    // zero limit keeps the sum at zero
    load_config(3, 50, 2, 10, 32767, -32768, 0);
    add_sample(4000, 10);
    add_sample(10, 4000);
    add_sample(700, 300);
    wait_idle();

    // floor above ceiling: output sits at the ceiling
    load_config(7, 1, 1, 100, -500, 500, 1000);
    add_sample(0, 4095);
    add_sample(4095, 0);
    add_sample(1234, 1234);
    wait_idle();

    // largest gains, bias and limit
    load_config(65535, 65535, 65535, 65535, 32767, -32768, 65535);
    add_sample(4095, 0);
    add_sample(4095, 0);
    add_sample(0, 4095);
    add_sample(0, 4095);
    wait_idle();

    for (int ph = 0; ph < RandPhases; ph++) begin
      case ($urandom_range(0, 3))
        0: begin
          c = 32767;
          f = -32768;
        end
        1: begin
          c = $urandom_range(0, 4000);
          f = -int'($urandom_range(0, 4000));
        end
        2: begin
          a = int'($signed(16'($urandom)));
          b = int'($signed(16'($urandom)));
          c = (a > b) ? a : b;
          f = (a > b) ? b : a;
        end
        default: begin
          f = $urandom_range(0, 2000);
          c = f - int'($urandom_range(1, 2000));
        end
      endcase
      a = $urandom_range(0, 3);
      b = (a == 0) ? 0 : (a == 1) ? 65535 : (a == 2) ? $urandom_range(0, 500)
                                                     : $urandom_range(0, 65535);
      load_config(pick_gain(), pick_gain(), pick_gain(), b, c, f, pick_limit());
      up = $urandom_range(0, 1);
      repeat (RandPerPhase) add_random_sample(up);
      wait_idle();
    end

    $display("Summary: %0d samples taken, %0d duty beats checked, %0d register settings",
             taken_cnt, checked_cnt, settings_cnt);
    $display("Covered accumulator clamping, zero limit, crossed limits and unmapped index");
    if (fail_cnt == 0 && duty_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d duty values still expected", fail_cnt, duty_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout: %0d of %0d duty beats seen", checked_cnt, queued_cnt);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
